// ===== sv/vtcg_pkg.sv =====
// Shared types, constants and helpers of the vario tone cadence generator.
`timescale 1ns / 1ps

package vtcg_pkg;

    localparam int RATE_W     = 16;              // vertical rate and rate registers
    localparam int EXT_W      = RATE_W + 1;      // signed differences of two rates
    localparam int TONE_W     = 12;              // one pitch
    localparam int TICK_W     = 8;               // one cadence tick count
    localparam int FAC_W      = TONE_W + 1;      // signed pitch difference or tick count
    localparam int LEN_W      = 16;              // lengths and counters
    localparam int NUM_W      = EXT_W + FAC_W;   // product fed to the divider
    localparam int DIV_STEPS  = NUM_W / 2;       // two quotient bits per cycle
    localparam int DCNT_W     = $clog2(DIV_STEPS + 1);
    localparam int TONES_W    = 4 * TONE_W;
    localparam int CADENCE_W  = 4 * TICK_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = TONES_W;
    localparam int FIFO_DEPTH = 2;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic REQ_RATE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLIMB_START      = 3'd0,
        CFG_CLIMB_MAX        = 3'd1,
        CFG_CLIMB_CONTINUOUS = 3'd2,
        CFG_SINK_ALARM       = 3'd3,
        CFG_SINK_MAX         = 3'd4,
        CFG_SINK_CONTINUOUS  = 3'd5,
        CFG_TONE_LIMITS      = 3'd6,
        CFG_CADENCE_LIMITS   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [RATE_W-1:0]    climb_start;
        logic [RATE_W-1:0]    climb_max;
        logic [RATE_W-1:0]    climb_continuous;
        logic [RATE_W-1:0]    sink_alarm;
        logic [RATE_W-1:0]    sink_max;
        logic [RATE_W-1:0]    sink_continuous;
        logic [TONES_W-1:0]   tone_limits;
        logic [CADENCE_W-1:0] cadence_limits;
    } t_cfg;

    typedef enum logic [2:0] {
        K_TICK,
        K_QUIET,
        K_DEAD,
        K_CLIMB,
        K_SINK
    } t_kind;

    // One classified item. For a band item: note quotient from a0*b0/d0,
    // length quotients from a1*b1/d1 and a1*b2/d1.
    typedef struct packed {
        t_kind                    kind;
        logic                     silenced;
        logic                     cont;
        logic [TONE_W-1:0]        base_note;
        logic [TICK_W-1:0]        base_a;
        logic [TICK_W-1:0]        base_b;
        logic signed [EXT_W-1:0]  a0;
        logic signed [FAC_W-1:0]  b0;
        logic signed [EXT_W-1:0]  d0;
        logic signed [EXT_W-1:0]  a1;
        logic signed [FAC_W-1:0]  b1;
        logic signed [FAC_W-1:0]  b2;
        logic signed [EXT_W-1:0]  d1;
    } t_cmd;

    typedef enum logic [1:0] {
        B_IDLE,
        B_LOAD,
        B_DIV,
        B_DONE
    } t_bstate;

    function automatic logic signed [EXT_W-1:0] sext(input logic [RATE_W-1:0] v);
        return {v[RATE_W-1], v};
    endfunction

endpackage

// ===== sv/vtcg_req_if.sv =====
// Request channel: valid/ready handshake carrying one input item.
`timescale 1ns / 1ps

interface vtcg_req_if;
    logic                              valid;
    logic                              ready;
    logic                              req_type;
    logic signed [vtcg_pkg::RATE_W-1:0] vertical_rate;
    logic                              quiet_hold;
    logic                              silenced;

    modport source(output valid, req_type, vertical_rate, quiet_hold, silenced,
                   input ready);
    modport sink(input valid, req_type, vertical_rate, quiet_hold, silenced,
                 output ready);
endinterface

// ===== sv/vtcg_res_if.sv =====
// Result channel: valid/ready handshake carrying one result item.
`timescale 1ns / 1ps

interface vtcg_res_if;
    logic                          valid;
    logic                          ready;
    logic [vtcg_pkg::TONE_W-1:0]   tone;
    logic                          resting;

    modport source(output valid, tone, resting, input ready);
    modport sink(input valid, tone, resting, output ready);
endinterface

// ===== sv/vtcg_div.sv =====
// Serial signed divider, two quotient bits per cycle, truncating toward zero.
`timescale 1ns / 1ps

module vtcg_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [vtcg_pkg::NUM_W-1:0]  i_num,
    input  logic signed [vtcg_pkg::EXT_W-1:0]  i_den,
    output logic                               o_done,
    output logic [vtcg_pkg::LEN_W-1:0]         o_quo
);
    import vtcg_pkg::*;

    logic              r_busy, n_busy;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic              r_neg, n_neg;
    logic              r_zero, n_zero;
    logic [NUM_W-1:0]  r_num, n_num;
    logic [EXT_W-1:0]  r_den, n_den;
    logic [EXT_W-1:0]  r_rem, n_rem;

    logic [EXT_W:0]    t1, t2, d1, d2;
    logic              ge1, ge2;
    logic [EXT_W-1:0]  rem1, rem2;
    logic [NUM_W-1:0]  num1, num2;
    logic [LEN_W-1:0]  q_mag;

    // two restoring steps
    always_comb begin
        t1   = {r_rem, r_num[NUM_W-1]};
        d1   = t1 - {1'b0, r_den};
        ge1  = t1 >= {1'b0, r_den};
        rem1 = ge1 ? d1[EXT_W-1:0] : t1[EXT_W-1:0];
        num1 = {r_num[NUM_W-2:0], ge1};
        t2   = {rem1, num1[NUM_W-1]};
        d2   = t2 - {1'b0, r_den};
        ge2  = t2 >= {1'b0, r_den};
        rem2 = ge2 ? d2[EXT_W-1:0] : t2[EXT_W-1:0];
        num2 = {num1[NUM_W-2:0], ge2};
    end

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_zero = r_zero;
        n_num  = r_num;
        n_den  = r_den;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DCNT_W'(DIV_STEPS);
            n_neg  = i_num[NUM_W-1] ^ i_den[EXT_W-1];
            n_zero = (i_den == '0);
            n_num  = i_num[NUM_W-1] ? (~i_num + NUM_W'(1)) : i_num;
            n_den  = i_den[EXT_W-1] ? (~i_den + EXT_W'(1)) : i_den;
            n_rem  = '0;
        end else if (r_busy && (r_cnt != '0)) begin
            n_cnt = r_cnt - DCNT_W'(1);
            n_num = num2;
            n_rem = rem2;
        end else if (r_busy) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_neg  <= n_neg;
        r_zero <= n_zero;
        r_num  <= n_num;
        r_den  <= n_den;
        r_rem  <= n_rem;
    end

    assign q_mag  = r_num[LEN_W-1:0];
    assign o_done = r_busy && (r_cnt == '0);
    assign o_quo  = r_zero ? '0 : (r_neg ? (~q_mag + LEN_W'(1)) : q_mag);

endmodule

// ===== sv/vtcg_fifo.sv =====
// Two-entry command queue between the classifier and the executor.
`timescale 1ns / 1ps

module vtcg_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vtcg_pkg::t_cmd i_data,
    input  logic           i_pop,
    output vtcg_pkg::t_cmd o_data,
    output logic           o_full,
    output logic           o_empty
);
    import vtcg_pkg::*;

    t_cmd              r_mem [FIFO_DEPTH];
    logic [FPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [FCNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == FCNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + FCNT_W'(1);
            2'b01:   n_count = r_count - FCNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + FPTR_W'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + FPTR_W'(1);
            r_count <= n_count;
        end
        if (i_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

// ===== sv/vtcg_front.sv =====
// Front end: accept items, classify rate items into bands and prepare divider operands.
`timescale 1ns / 1ps

module vtcg_front (
    vtcg_req_if.sink       i_req,
    input  vtcg_pkg::t_cfg i_cfg,
    input  logic           i_full,
    output logic           o_push,
    output vtcg_pkg::t_cmd o_cmd
);
    import vtcg_pkg::*;

    logic signed [EXT_W-1:0] rate, cs, cm, cc, sa, sm, sc, cl_c, cl_s;
    logic [TONE_W-1:0]       p0, p1, p2, p3;
    logic [TICK_W-1:0]       t0, t1, t2, t3;
    logic                    climb, sinkb;

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    always_comb begin
        rate = sext(i_req.vertical_rate);
        cs   = sext(i_cfg.climb_start);
        cm   = sext(i_cfg.climb_max);
        cc   = sext(i_cfg.climb_continuous);
        sa   = sext(i_cfg.sink_alarm);
        sm   = sext(i_cfg.sink_max);
        sc   = sext(i_cfg.sink_continuous);
        p0   = i_cfg.tone_limits[0*TONE_W +: TONE_W];
        p1   = i_cfg.tone_limits[1*TONE_W +: TONE_W];
        p2   = i_cfg.tone_limits[2*TONE_W +: TONE_W];
        p3   = i_cfg.tone_limits[3*TONE_W +: TONE_W];
        t0   = i_cfg.cadence_limits[0*TICK_W +: TICK_W];
        t1   = i_cfg.cadence_limits[1*TICK_W +: TICK_W];
        t2   = i_cfg.cadence_limits[2*TICK_W +: TICK_W];
        t3   = i_cfg.cadence_limits[3*TICK_W +: TICK_W];

        climb = (rate >= cs);
        sinkb = (sa < 0) && (rate <= sa);
        cl_c  = (rate > cm) ? cm : rate;
        cl_s  = (rate < sm) ? sm : rate;

        o_cmd.silenced = i_req.silenced;
        if (climb) begin
            o_cmd.cont      = (rate >= cc);
            o_cmd.base_note = p0;
            o_cmd.base_a    = t0;
            o_cmd.base_b    = t1;
            o_cmd.a0        = cl_c - cs;
            o_cmd.b0        = {1'b0, p1} - {1'b0, p0};
            o_cmd.d0        = cm - cs;
            o_cmd.a1        = rate - cs;
            o_cmd.b1        = {{(FAC_W-TICK_W){1'b0}}, t0};
            o_cmd.b2        = {{(FAC_W-TICK_W){1'b0}}, t1};
            o_cmd.d1        = cc - cs;
        end else begin
            // sink band; the same quotient serves both lengths
            o_cmd.cont      = (rate <= sc);
            o_cmd.base_note = p2;
            o_cmd.base_a    = t3;
            o_cmd.base_b    = t2;
            o_cmd.a0        = sa - cl_s;
            o_cmd.b0        = {1'b0, p2} - {1'b0, p3};
            o_cmd.d0        = sa - sm;
            o_cmd.a1        = sa - rate;
            o_cmd.b1        = {{(FAC_W-TICK_W){1'b0}}, t2};
            o_cmd.b2        = {{(FAC_W-TICK_W){1'b0}}, t2};
            o_cmd.d1        = sa - sc;
        end

        priority if (i_req.req_type == REQ_TICK) o_cmd.kind = K_TICK;
        else if (i_req.quiet_hold)               o_cmd.kind = K_QUIET;
        else if (climb)                          o_cmd.kind = K_CLIMB;
        else if (sinkb)                          o_cmd.kind = K_SINK;
        else                                     o_cmd.kind = K_DEAD;
    end

endmodule

// ===== sv/vtcg_back.sv =====
// Back end: execute queued commands, own the note and cadence state, hold the result register.
`timescale 1ns / 1ps

module vtcg_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  vtcg_pkg::t_cmd i_cmd,
    input  logic           i_empty,
    output logic           o_pop,
    vtcg_res_if.source     o_res
);
    import vtcg_pkg::*;

    t_bstate           r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [1:0]        r_slot, n_slot;
    logic [LEN_W-1:0]  r_q [3];
    logic [LEN_W-1:0]  n_q [3];

    logic [TONE_W-1:0] r_note, n_note;
    logic [LEN_W-1:0]  r_play_len, n_play_len, r_rest_len, n_rest_len;
    logic [LEN_W-1:0]  r_play_cnt, n_play_cnt, r_rest_cnt, n_rest_cnt;
    logic              r_between, n_between;

    logic              r_out_valid, n_out_valid;
    logic [TONE_W-1:0] r_tone, n_tone;
    logic              r_resting, n_resting;

    logic                    out_free, head_band, div_start, div_done;
    logic [LEN_W-1:0]        div_quo, play_inc, rest_inc;
    logic signed [EXT_W-1:0] mul_a, mul_d;
    logic signed [FAC_W-1:0] mul_b;
    logic signed [NUM_W-1:0] prod;

    assign out_free  = !r_out_valid || o_res.ready;
    assign head_band = (i_cmd.kind == K_CLIMB) || (i_cmd.kind == K_SINK);
    assign play_inc  = r_play_cnt + LEN_W'(1);
    assign rest_inc  = r_rest_cnt + LEN_W'(1);
    assign prod      = mul_a * mul_b;

    vtcg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (prod),
        .i_den   (mul_d),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (!i_empty && head_band) n_state = B_LOAD;
            B_LOAD: n_state = B_DIV;
            B_DIV: begin
                if (div_done) n_state = (r_slot == 2'd2) ? B_DONE : B_LOAD;
            end
            B_DONE: if (out_free) n_state = B_IDLE;
        endcase
    end

    // control outputs and operand selection
    always_comb begin
        o_pop     = (r_state == B_IDLE) && !i_empty && (head_band || out_free);
        div_start = (r_state == B_LOAD);
        unique case (r_slot)
            2'd1: begin
                mul_a = r_cmd.a1;
                mul_b = r_cmd.b1;
                mul_d = r_cmd.d1;
            end
            2'd2: begin
                mul_a = r_cmd.a1;
                mul_b = r_cmd.b2;
                mul_d = r_cmd.d1;
            end
            default: begin
                mul_a = r_cmd.a0;
                mul_b = r_cmd.b0;
                mul_d = r_cmd.d0;
            end
        endcase
    end

    // datapath
    always_comb begin
        n_cmd       = r_cmd;
        n_slot      = r_slot;
        n_q         = r_q;
        n_note      = r_note;
        n_play_len  = r_play_len;
        n_rest_len  = r_rest_len;
        n_play_cnt  = r_play_cnt;
        n_rest_cnt  = r_rest_cnt;
        n_between   = r_between;
        n_out_valid = r_out_valid && !o_res.ready;
        n_tone      = r_tone;
        n_resting   = r_resting;

        unique case (r_state)
            B_IDLE: begin
                if (o_pop && head_band) begin
                    n_cmd  = i_cmd;
                    n_slot = 2'd0;
                end else if (o_pop) begin
                    n_out_valid = 1'b1;
                    n_tone      = '0;
                    n_resting   = 1'b0;
                    unique case (i_cmd.kind)
                        K_TICK: begin
                            if (!i_cmd.silenced && (r_note != '0)) begin
                                if (r_between) begin
                                    n_resting = 1'b1;
                                    if (rest_inc >= r_rest_len) begin
                                        n_rest_cnt = '0;
                                        n_between  = 1'b0;
                                    end else begin
                                        n_rest_cnt = rest_inc;
                                    end
                                end else begin
                                    n_tone = r_note;
                                    if (play_inc >= r_play_len) begin
                                        n_play_cnt = '0;
                                        if (r_rest_len != '0) n_between = 1'b1;
                                    end else begin
                                        n_play_cnt = play_inc;
                                    end
                                end
                            end
                        end
                        K_QUIET: n_note = '0;
                        K_DEAD: begin
                            n_note     = '0;
                            n_play_len = '0;
                            n_rest_len = '0;
                            n_play_cnt = '0;
                            n_rest_cnt = '0;
                            n_between  = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            B_LOAD: ;
            B_DIV: begin
                if (div_done) begin
                    n_q[r_slot] = div_quo;
                    n_slot      = r_slot + 2'd1;
                end
            end
            B_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_tone      = '0;
                    n_resting   = 1'b0;
                    if (r_cmd.kind == K_SINK) begin
                        n_note     = r_cmd.base_note - r_q[0][TONE_W-1:0];
                        n_play_len = {{(LEN_W-TICK_W){1'b0}}, r_cmd.base_a} + r_q[1];
                    end else begin
                        n_note     = r_cmd.base_note + r_q[0][TONE_W-1:0];
                        n_play_len = {{(LEN_W-TICK_W){1'b0}}, r_cmd.base_a} - r_q[1];
                    end
                    n_rest_len = {{(LEN_W-TICK_W){1'b0}}, r_cmd.base_b} - r_q[2];
                    if (r_cmd.cont) begin
                        n_play_len = LEN_W'(1);
                        n_rest_len = '0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_slot      <= '0;
            r_note      <= '0;
            r_play_len  <= '0;
            r_rest_len  <= '0;
            r_play_cnt  <= '0;
            r_rest_cnt  <= '0;
            r_between   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_note      <= n_note;
            r_play_len  <= n_play_len;
            r_rest_len  <= n_rest_len;
            r_play_cnt  <= n_play_cnt;
            r_rest_cnt  <= n_rest_cnt;
            r_between   <= n_between;
            r_out_valid <= n_out_valid;
        end
        r_cmd     <= n_cmd;
        r_q       <= n_q;
        r_tone    <= n_tone;
        r_resting <= n_resting;
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.tone    = r_tone;
    assign o_res.resting = r_resting;

endmodule

// ===== sv/vario_tone_cadence_generator.sv =====
// Top level of the vario tone cadence generator: configuration registers and block wiring.
`timescale 1ns / 1ps

// Turns vertical-speed transactions into a beep tone and a play/rest cadence,
// one result transaction per request. A rate request (req_type 0) sets the
// note and the beep/rest lengths from the climb or sink band, or clears them
// in the deadband; quiet_hold drops only the note. A tick request (req_type 1)
// is one 40 ms slot: it returns the tone (or silence with resting set) and
// advances the cadence; silenced freezes the cadence and returns silence.
// Requests are classified in the front end and queued two deep, so the request
// side keeps accepting while the executor or the result side stalls until the
// queue fills. Tick, quiet-hold and deadband requests leave the executor at
// one per cycle while the result side is ready. A rate request inside a band
// waits while the single shared divider gets the three interpolation
// quotients in turn at two bits per cycle (15 steps plus load and hand-over
// each). Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data
// only while the block is idle, a user's rule the block does not enforce.
// There is no read-back; registers reset to the register-map defaults.
module vario_tone_cadence_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    vtcg_req_if.sink                            i_req,
    vtcg_res_if.source                          o_res,
    input  logic                                i_cfg_we,
    input  logic [vtcg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [vtcg_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import vtcg_pkg::*;

    t_cfg r_cfg, n_cfg;
    t_cmd front_cmd, head_cmd;
    logic push, pop, full, empty;

    // Register write: each register takes the low bits of the write data.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CLIMB_START:      n_cfg.climb_start      = i_cfg_data[RATE_W-1:0];
                CFG_CLIMB_MAX:        n_cfg.climb_max        = i_cfg_data[RATE_W-1:0];
                CFG_CLIMB_CONTINUOUS: n_cfg.climb_continuous = i_cfg_data[RATE_W-1:0];
                CFG_SINK_ALARM:       n_cfg.sink_alarm       = i_cfg_data[RATE_W-1:0];
                CFG_SINK_MAX:         n_cfg.sink_max         = i_cfg_data[RATE_W-1:0];
                CFG_SINK_CONTINUOUS:  n_cfg.sink_continuous  = i_cfg_data[RATE_W-1:0];
                CFG_TONE_LIMITS:      n_cfg.tone_limits      = i_cfg_data[TONES_W-1:0];
                CFG_CADENCE_LIMITS:   n_cfg.cadence_limits   = i_cfg_data[CADENCE_W-1:0];
            endcase
        end
    end

    // Defaults: climb beeps from 50 cm/s, top pitch at 800, continuous at
    // 1100; sink alarm off, sink floor -1000, continuous at -800.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.climb_start      <= RATE_W'(50);
            r_cfg.climb_max        <= RATE_W'(800);
            r_cfg.climb_continuous <= RATE_W'(1100);
            r_cfg.sink_alarm       <= '0;
            r_cfg.sink_max         <= RATE_W'(-1000);
            r_cfg.sink_continuous  <= RATE_W'(-800);
            r_cfg.tone_limits      <= '0;
            r_cfg.cadence_limits   <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Front end: accept and classify.
    vtcg_front u_front (
        .i_req  (i_req),
        .i_cfg  (r_cfg),
        .i_full (full),
        .o_push (push),
        .o_cmd  (front_cmd)
    );

    // Decoupling queue.
    vtcg_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .i_pop   (pop),
        .o_data  (head_cmd),
        .o_full  (full),
        .o_empty (empty)
    );

    // Executor with cadence state, divider and result register.
    vtcg_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

// ===== test/vtcg_cadence_checker.sv =====
// Cadence checker: mirrors the tone generator, predicts each result transaction and compares it.
`timescale 1ns / 1ps

module vtcg_cadence_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    vtcg_req_if                               i_req,
    vtcg_res_if                               i_res,
    input  logic                              i_cfg_we,
    input  logic [vtcg_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [vtcg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                                o_mismatches,
    output int                                o_pending
);

    import vtcg_pkg::*;

    typedef struct packed {
        logic [TONE_W-1:0] tone;
        logic              resting;
    } t_beep;

    t_cfg              cfg_copy;
    logic [TONE_W-1:0] note;
    logic [LEN_W-1:0]  play_len;
    logic [LEN_W-1:0]  rest_len;
    logic [LEN_W-1:0]  play_cnt;
    logic [LEN_W-1:0]  rest_cnt;
    logic              between_beeps;
    t_beep             beep_queue [$];
    int                mismatches = 0;
    int                pending = 0;

    assign o_mismatches = mismatches;
    assign o_pending    = pending;

    function automatic int as_rate(input logic [RATE_W-1:0] v);
        return int'($signed(v));
    endfunction

    function automatic int tone_at(input int k);
        return int'(cfg_copy.tone_limits[TONE_W*k +: TONE_W]);
    endfunction

    function automatic int tick_at(input int k);
        return int'(cfg_copy.cadence_limits[TICK_W*k +: TICK_W]);
    endfunction

    // truncating division, zero divisor gives zero
    function automatic int quot(input int num, input int den);
        return (den == 0) ? 0 : num / den;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    // New vertical rate: pick the band, interpolate note and lengths
    task automatic retune(input int rate);
        int cs, cm, cc, sa, sm, sc;
        int clamp, n, pl, rl, prog, span;
        cs = as_rate(cfg_copy.climb_start);
        cm = as_rate(cfg_copy.climb_max);
        cc = as_rate(cfg_copy.climb_continuous);
        sa = as_rate(cfg_copy.sink_alarm);
        sm = as_rate(cfg_copy.sink_max);
        sc = as_rate(cfg_copy.sink_continuous);
        n  = 0;
        pl = 0;
        rl = 0;
        if (rate >= cs) begin
            clamp = (rate > cm) ? cm : rate;
            n = tone_at(0) + quot((clamp - cs) * (tone_at(1) - tone_at(0)), cm - cs);
            if (rate >= cc) begin
                pl = 1;
            end else begin
                prog = rate - cs;
                span = cc - cs;
                pl = tick_at(0) - quot(prog * tick_at(0), span);
                rl = tick_at(1) - quot(prog * tick_at(1), span);
            end
        end else if (sa < 0 && rate <= sa) begin
            clamp = (rate < sm) ? sm : rate;
            n = tone_at(2) - quot((sa - clamp) * (tone_at(2) - tone_at(3)), sa - sm);
            if (rate <= sc) begin
                pl = 1;
            end else begin
                prog = sa - rate;
                span = sa - sc;
                rl = tick_at(2) - quot(prog * tick_at(2), span);
                pl = tick_at(3) + (tick_at(2) - rl);
            end
        end else begin
            between_beeps = 1'b0;
            play_cnt      = '0;
            rest_cnt      = '0;
        end
        note     = n[TONE_W-1:0];
        play_len = pl[LEN_W-1:0];
        rest_len = rl[LEN_W-1:0];
    endtask

    // One 40 ms slot: beep, rest gap or silence
    task automatic play_slot(input logic mute, output t_beep beep);
        beep = '0;
        if (!mute && note != '0) begin
            if (between_beeps) begin
                beep.resting = 1'b1;
                rest_cnt = rest_cnt + 1'b1;
                if (rest_cnt >= rest_len) begin
                    rest_cnt      = '0;
                    between_beeps = 1'b0;
                end
            end else begin
                beep.tone = note;
                play_cnt = play_cnt + 1'b1;
                if (play_cnt >= play_len) begin
                    play_cnt = '0;
                    if (rest_len != '0)
                        between_beeps = 1'b1;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_beep beep;
        t_beep oldest;
        if (!i_rst_n) begin
            cfg_copy.climb_start      = 16'd50;
            cfg_copy.climb_max        = 16'd800;
            cfg_copy.climb_continuous = 16'd1100;
            cfg_copy.sink_alarm       = 16'd0;
            cfg_copy.sink_max         = -16'sd1000;
            cfg_copy.sink_continuous  = -16'sd800;
            cfg_copy.tone_limits      = '0;
            cfg_copy.cadence_limits   = '0;
            note          = '0;
            play_len      = '0;
            rest_len      = '0;
            play_cnt      = '0;
            rest_cnt      = '0;
            between_beeps = 1'b0;
            beep_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_CLIMB_START:      cfg_copy.climb_start      = i_cfg_data[RATE_W-1:0];
                    CFG_CLIMB_MAX:        cfg_copy.climb_max        = i_cfg_data[RATE_W-1:0];
                    CFG_CLIMB_CONTINUOUS: cfg_copy.climb_continuous = i_cfg_data[RATE_W-1:0];
                    CFG_SINK_ALARM:       cfg_copy.sink_alarm       = i_cfg_data[RATE_W-1:0];
                    CFG_SINK_MAX:         cfg_copy.sink_max         = i_cfg_data[RATE_W-1:0];
                    CFG_SINK_CONTINUOUS:  cfg_copy.sink_continuous  = i_cfg_data[RATE_W-1:0];
                    CFG_TONE_LIMITS:      cfg_copy.tone_limits      = i_cfg_data[TONES_W-1:0];
                    CFG_CADENCE_LIMITS:   cfg_copy.cadence_limits   = i_cfg_data[CADENCE_W-1:0];
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                if (beep_queue.size() == 0) begin
                    report_mismatch($sformatf("result tone %0d resting %0b with nothing expected",
                                              i_res.tone, i_res.resting));
                end else begin
                    oldest = beep_queue.pop_front();
                    if (i_res.tone !== oldest.tone)
                        report_mismatch($sformatf("tone %0d, expected %0d",
                                                  i_res.tone, oldest.tone));
                    if (i_res.resting !== oldest.resting)
                        report_mismatch($sformatf("resting %0b, expected %0b",
                                                  i_res.resting, oldest.resting));
                end
            end
            if (i_req.valid && i_req.ready) begin
                beep = '0;
                if (i_req.req_type == REQ_RATE) begin
                    if (i_req.quiet_hold == 1'b1)
                        note = '0;
                    else
                        retune(as_rate(i_req.vertical_rate));
                end else begin
                    play_slot(i_req.silenced, beep);
                end
                beep_queue.push_back(beep);
            end
        end
        pending = beep_queue.size();
    end

endmodule

// ===== test/vario_tone_cadence_generator_tb.sv =====
// Testbench top of the vario tone cadence generator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module vario_tone_cadence_generator_tb;

    import vtcg_pkg::*;

    localparam int STALL_LIMIT = 5000;   // cycles without any transaction before giving up
    localparam int HOLD_CYCLES = 300;    // long receiver hold-off
    localparam int TAIL_CYCLES = 60;     // covers the slowest band request

    // Band edges and rail values for the directed walk, typical settings assumed
    localparam logic [RATE_W-1:0] DIRECTED_RATES [10] = '{
        16'd50,      // climb start exactly
        16'd800,     // top climb pitch
        16'd1100,    // continuous climb tone
        16'h7FFF,    // fastest climb
        16'd49,      // just inside the deadband
        16'hFF38,    // -200, sink alarm exactly
        16'hFC18,    // -1000, lowest sink pitch
        16'h8000,    // fastest sink
        16'hFCE0,    // -800, continuous sink tone
        16'd600      // mid climb, leaves a note for the silence cases
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int   src_idle_pct;
    int   snk_idle_pct;
    logic hold_request = 1'b0;
    int   stall_cycles = 0;
    int   fail_count;
    int   pending;

    vtcg_req_if req_ch ();
    vtcg_res_if res_ch ();

    vario_tone_cadence_generator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    vtcg_cadence_checker u_cadence_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // Offer one request transaction and hold it until it is taken. Entered and left
    // just after a falling edge; valid stays high on return so that a following
    // transaction runs back to back, and callers that stop sending must drop it.
    task automatic send_item(input logic kind, input logic [RATE_W-1:0] rate,
                             input logic hold, input logic mute);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= kind;
        req_ch.vertical_rate <= rate;
        req_ch.quiet_hold    <= hold;
        req_ch.silenced      <= mute;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every predicted result has been taken
    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    // Receiver: random back-pressure, plus a long hold-off on request. The request
    // is picked up at the rising edge so it never races with the falling-edge drive.
    initial begin : receiver
        int hold_left;
        int idle_pct;
        hold_left    = 0;
        idle_pct     = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            idle_pct = snk_idle_pct;
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            @(negedge i_clk);
            if (hold_left > 0) begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    // Watchdog: count cycles in which no transaction and no register write happens
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        wait (stall_cycles >= STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        t_cfg                  settings;
        t_cfg_idx              reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [RATE_W-1:0]     rate;
        logic                  kind;
        logic                  hold;
        logic                  mute;
        int                    phase;
        int                    i;
        int                    k;
        int                    n_items;

        // Every input known from time zero, with reset asserted
        i_rst_n              = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = REQ_TICK;
        req_ch.vertical_rate = '0;
        req_ch.quiet_hold    = 1'b0;
        req_ch.silenced      = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = '0;
        cfg_data             = '0;
        src_idle_pct         = 33;
        snk_idle_pct         = 58;

        // Mirror of the reset values, used only to aim random rates at the edges
        settings.climb_start      = 16'd50;
        settings.climb_max        = 16'd800;
        settings.climb_continuous = 16'd1100;
        settings.sink_alarm       = 16'd0;
        settings.sink_max         = -16'sd1000;
        settings.sink_continuous  = -16'sd800;
        settings.tone_limits      = '0;
        settings.cadence_limits   = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Phase 0 runs on the reset values; later phases load a full register set first
        for (phase = 0; phase < 7; phase++) begin
            if (phase != 0) begin
                drain();
                case (phase)
                    1: begin
                        // typical flying setup, small cadence counts
                        settings.climb_start      = 16'd50;
                        settings.climb_max        = 16'd800;
                        settings.climb_continuous = 16'd1100;
                        settings.sink_alarm       = -16'sd200;
                        settings.sink_max         = -16'sd1000;
                        settings.sink_continuous  = -16'sd800;
                        settings.tone_limits      = {12'd200, 12'd400, 12'd1500, 12'd700};
                        settings.cadence_limits   = {8'd4, 8'd6, 8'd8, 8'd10};
                    end
                    2: begin
                        // collapsed bands: every divisor is zero
                        settings.climb_start      = 16'd100;
                        settings.climb_max        = 16'd100;
                        settings.climb_continuous = 16'd100;
                        settings.sink_alarm       = -16'sd100;
                        settings.sink_max         = -16'sd100;
                        settings.sink_continuous  = -16'sd100;
                        settings.tone_limits      = TONES_W'({$urandom, $urandom});
                        for (k = 0; k < 4; k++)
                            settings.cadence_limits[8*k +: 8] = 8'($urandom_range(0, 6));
                    end
                    3: begin
                        // widest climb band, all pitches and counts at the top
                        settings.climb_start      = 16'h8000;
                        settings.climb_max        = 16'h7FFF;
                        settings.climb_continuous = 16'h7FFF;
                        settings.sink_alarm       = 16'h8000;
                        settings.sink_max         = 16'h7FFF;
                        settings.sink_continuous  = 16'h7FFF;
                        settings.tone_limits      = '1;
                        settings.cadence_limits   = '1;
                    end
                    4: begin
                        // inverted climb band, sink alarm at -1, zero-length cadence
                        settings.climb_start      = 16'h7FFF;
                        settings.climb_max        = 16'h8000;
                        settings.climb_continuous = 16'h8000;
                        settings.sink_alarm       = 16'hFFFF;
                        settings.sink_max         = 16'h8000;
                        settings.sink_continuous  = 16'h8000;
                        settings.tone_limits      = {12'hFFF, 12'h000, 12'h000, 12'hFFF};
                        settings.cadence_limits   = '0;
                    end
                    5: begin
                        // random but sensibly ordered bands
                        settings.climb_start      = 16'($urandom_range(0, 300));
                        settings.climb_max        = settings.climb_start
                                                    + 16'($urandom_range(0, 1500));
                        settings.climb_continuous = settings.climb_start
                                                    + 16'($urandom_range(0, 2000));
                        settings.sink_alarm       = 16'd0 - 16'($urandom_range(0, 300));
                        settings.sink_max         = settings.sink_alarm
                                                    - 16'($urandom_range(0, 1500));
                        settings.sink_continuous  = settings.sink_alarm
                                                    - 16'($urandom_range(0, 1500));
                        settings.tone_limits      = TONES_W'({$urandom, $urandom});
                        for (k = 0; k < 4; k++)
                            settings.cadence_limits[8*k +: 8] = 8'($urandom_range(0, 12));
                    end
                    default: begin
                        // anything goes
                        settings.climb_start      = 16'($urandom);
                        settings.climb_max        = 16'($urandom);
                        settings.climb_continuous = 16'($urandom);
                        settings.sink_alarm       = 16'($urandom);
                        settings.sink_max         = 16'($urandom);
                        settings.sink_continuous  = 16'($urandom);
                        settings.tone_limits      = TONES_W'({$urandom, $urandom});
                        settings.cadence_limits   = $urandom;
                    end
                endcase

                // Block is idle here: write all eight registers on consecutive edges
                for (i = 0; i < 8; i++) begin
                    reg_idx = t_cfg_idx'(i);
                    case (reg_idx)
                        CFG_CLIMB_START:      reg_data = CFG_DATA_W'(settings.climb_start);
                        CFG_CLIMB_MAX:        reg_data = CFG_DATA_W'(settings.climb_max);
                        CFG_CLIMB_CONTINUOUS: reg_data = CFG_DATA_W'(settings.climb_continuous);
                        CFG_SINK_ALARM:       reg_data = CFG_DATA_W'(settings.sink_alarm);
                        CFG_SINK_MAX:         reg_data = CFG_DATA_W'(settings.sink_max);
                        CFG_SINK_CONTINUOUS:  reg_data = CFG_DATA_W'(settings.sink_continuous);
                        CFG_TONE_LIMITS:      reg_data = CFG_DATA_W'(settings.tone_limits);
                        default:              reg_data = CFG_DATA_W'(settings.cadence_limits);
                    endcase
                    cfg_we   <= 1'b1;
                    cfg_idx  <= reg_idx;
                    cfg_data <= reg_data;
                    @(negedge i_clk);
                end
                cfg_we <= 1'b0;
            end

            // Idling pattern: slow receiver first, then slow sender, then full speed
            if (phase < 3) begin
                src_idle_pct = 33;
                snk_idle_pct = 58;
            end else if (phase < 5) begin
                src_idle_pct = 58;
                snk_idle_pct = 33;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end

            if (phase == 1) begin
                // Directed walk: each band edge followed by one slot to hear the result
                for (i = 0; i < 10; i++) begin
                    send_item(REQ_RATE, DIRECTED_RATES[i], 1'b0, 1'b0);
                    send_item(REQ_TICK, '0, 1'b0, 1'b0);
                end
                send_item(REQ_TICK, '0, 1'b0, 1'b1);        // muted slot freezes the cadence
                send_item(REQ_RATE, 16'd600, 1'b1, 1'b0);   // quiet hold drops only the note
                send_item(REQ_TICK, '0, 1'b0, 1'b0);        // no note: silence
            end

            n_items = (phase == 0) ? 100 : 225;
            for (i = 0; i < n_items; i++) begin
                // Long receiver hold-off while requests keep coming: fill the queue
                if ((phase == 2 && i == 100) || (phase == 5 && i == 60))
                    hold_request = 1'b1;
                // Pause the sender until every result is back
                if (phase == 3 && i == 120)
                    drain();

                kind = ($urandom_range(0, 99) < 35) ? REQ_RATE : REQ_TICK;
                if ($urandom_range(0, 3) == 0) begin
                    rate = RATE_W'($urandom);
                end else begin
                    // aim near one of the band edges
                    case ($urandom_range(0, 5))
                        0:       rate = settings.climb_start;
                        1:       rate = settings.climb_max;
                        2:       rate = settings.climb_continuous;
                        3:       rate = settings.sink_alarm;
                        4:       rate = settings.sink_max;
                        default: rate = settings.sink_continuous;
                    endcase
                    rate = rate + RATE_W'($urandom_range(0, 600)) - RATE_W'(300);
                end
                // quiet hold mostly off so that notes survive; mute rare on slots
                hold = (kind == REQ_RATE) ? ($urandom_range(0, 9) == 0) : 1'($urandom);
                mute = (kind == REQ_TICK) ? ($urandom_range(0, 6) == 0) : 1'($urandom);
                send_item(kind, rate, hold, mute);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== vario_tone_cadence_generator.f =====
sv/vtcg_pkg.sv
sv/vtcg_req_if.sv
sv/vtcg_res_if.sv
sv/vtcg_div.sv
sv/vtcg_fifo.sv
sv/vtcg_front.sv
sv/vtcg_back.sv
sv/vario_tone_cadence_generator.sv
test/vtcg_cadence_checker.sv
test/vario_tone_cadence_generator_tb.sv
